// File: hdl/mrr_pkg.sv
`default_nettype none

package mrr_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BYTES_W = 31;
  localparam int unsigned LOG_W = 5;
  localparam int unsigned MIN_LOG2 = 5;
  localparam int unsigned DEFAULT_LIMIT_LOG2 = 31;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic fail;
    logic hit;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/mrr_in_if.sv
`default_nettype none

interface mrr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_address;
  logic [31:0] block_bytes;

  modport source (output valid, output start_address, output block_bytes, input ready);
  modport sink (input valid, input start_address, input block_bytes, output ready);
endinterface

`default_nettype wire

// File: hdl/mrr_out_if.sv
`default_nettype none

interface mrr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] region_base;
  logic [30:0] region_bytes;
  logic [4:0]  region_log2;
  logic        failed;

  modport source (output valid, output region_base, output region_bytes,
                  output region_log2, output failed, input ready);
  modport sink (input valid, input region_base, input region_bytes,
                input region_log2, input failed, output ready);
endinterface

`default_nettype wire

// File: hdl/mrr_datapath.sv
`default_nettype none

module mrr_datapath
  import mrr_pkg::*;
#(
  parameter int unsigned LIMIT_LOG2 = DEFAULT_LIMIT_LOG2
) (
  input  wire logic               clk,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [ADDR_W-1:0]  start_address,
  input  wire logic [ADDR_W-1:0]  block_bytes,
  output logic [ADDR_W-1:0]       region_base,
  output logic [BYTES_W-1:0]      region_bytes,
  output logic [LOG_W-1:0]        region_log2,
  output logic                    failed
);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] len;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W:0]   pow;
  logic [LOG_W-1:0]  lg;
  logic              short_len;
  logic [ADDR_W:0]   sum;

  // candidate region fits once len plus slack stays within 2^lg
  assign sum = {1'b0, len} + {1'b0, addr & mask};
  assign sts.hit = (sum <= pow);
  assign sts.fail = short_len || (lg >= LOG_W'(LIMIT_LOG2));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr      <= start_address;
      len       <= block_bytes;
      lg        <= LOG_W'(MIN_LOG2);
      mask      <= (ADDR_W'(1) << MIN_LOG2) - ADDR_W'(1);
      pow       <= (ADDR_W + 1)'(1) << MIN_LOG2;
      short_len <= (block_bytes < (ADDR_W'(1) << MIN_LOG2));
    end else if (cmd.step) begin
      lg   <= lg + LOG_W'(1);
      mask <= {mask[ADDR_W-2:0], 1'b1};
      pow  <= {pow[ADDR_W-1:0], 1'b0};
    end
    if (cmd.commit) begin
      failed       <= sts.fail;
      region_base  <= sts.fail ? '0 : (addr & ~mask);
      region_bytes <= sts.fail ? '0 : pow[BYTES_W-1:0];
      region_log2  <= sts.fail ? '0 : lg;
    end
  end

  assert property (@(posedge clk) cmd.step |-> !sts.fail && !sts.hit)
    else $error("step taken on a finished search");
  assert property (@(posedge clk) $past(cmd.step) |-> lg != LOG_W'(MIN_LOG2))
    else $error("log2 wrapped");
  assert property (@(posedge clk) $past(cmd.commit) && failed |->
                   region_base == '0 && region_bytes == '0 && region_log2 == '0)
    else $error("failed result carries nonzero fields");

endmodule

`default_nettype wire

// File: hdl/mrr_control.sv
`default_nettype none

module mrr_control
  import mrr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   finish;
  logic   slot_free;

  assign finish    = sts.fail || sts.hit;
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!finish) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> finish && slot_free)
    else $error("result written over a pending transfer");
  assert property (@(posedge clk) disable iff (rst) req_valid && req_ready |=> state == ST_RUN)
    else $error("accepted request did not start a search");
  assert property (@(posedge clk) disable iff (rst) state == ST_HOLD |-> finish)
    else $error("hold state without a finished search");

endmodule

`default_nettype wire

// File: hdl/mpu_region_rounder.sv
// channel | dir | fields
// req     | in  | start_address[31:0], block_bytes[31:0]
// rsp     | out | region_base[31:0], region_bytes[30:0], region_log2[4:0], failed
//
// One request at a time: the request is loaded, then candidate log2 values are tried
// from 5 upward until a fit or a failure is found and the result registers.
// The size search checks each candidate through the single adder/compare.
// rst is synchronous; it empties the result register and returns to idle.
// The result register holds a transfer while rsp is stalled; a new request is
// taken meanwhile, and its search stalls only when it finishes before rsp drains.
`default_nettype none

module mpu_region_rounder
  import mrr_pkg::*;
#(
  parameter int unsigned LIMIT_LOG2 = DEFAULT_LIMIT_LOG2
) (
  input wire logic clk,
  input wire logic rst,
  mrr_in_if.sink   req,
  mrr_out_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  mrr_control u_control (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrr_datapath #(
    .LIMIT_LOG2 (LIMIT_LOG2)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .start_address (req.start_address),
    .block_bytes   (req.block_bytes),
    .region_base   (rsp.region_base),
    .region_bytes  (rsp.region_bytes),
    .region_log2   (rsp.region_log2),
    .failed        (rsp.failed)
  );

endmodule

`default_nettype wire

// File: verif/mpu_region_rounder_chk.sv
module mpu_region_rounder_chk
  import mrr_pkg::*;
#(
  parameter int unsigned LIMIT_LOG2 = DEFAULT_LIMIT_LOG2
) (
  input  logic clk,
  input  logic rst,
  mrr_in_if    req,
  mrr_out_if   rsp,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [BYTES_W-1:0] bytes;
    logic [LOG_W-1:0]   lg;
    logic               failed;
  } region_t;

  region_t pending_regions[$];
  int      err_cnt = 0;
  int      open_cnt = 0;

  assign errors  = err_cnt;
  assign pending = open_cnt;

  function automatic int unsigned log2_ceil(input logic [63:0] v);
    int unsigned k;
    k = 0;
    while (k < 63 && (64'd1 << k) < v) k++;
    return k;
  endfunction

  function automatic region_t region_cover(input logic [31:0] addr, input logic [31:0] len);
    region_t     r;
    logic [63:0] sz;
    logic [63:0] aligned;
    logic [63:0] limit;
    int unsigned lg;
    int unsigned nxt;
    bit          done;
    r        = '0;
    r.failed = 1'b1;
    limit    = 64'd1 << LIMIT_LOG2;
    if (len >= 32'd32) begin
      lg   = log2_ceil({32'd0, len});
      done = 1'b0;
      for (int rounds = 0; rounds < 64 && !done; rounds++) begin
        sz = 64'd1 << lg;
        if (sz >= limit) begin
          done = 1'b1;
        end else begin
          aligned = {32'd0, addr} & ~(sz - 64'd1);
          nxt     = log2_ceil({32'd0, len} + ({32'd0, addr} - aligned));
          if (nxt == lg) begin
            r.base   = aligned[31:0];
            r.bytes  = sz[BYTES_W-1:0];
            r.lg     = lg[LOG_W-1:0];
            r.failed = 1'b0;
            done     = 1'b1;
          end else begin
            lg = nxt;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    region_t want;
    if (!rst) begin
      if (req.valid && req.ready)
        pending_regions.push_back(region_cover(req.start_address, req.block_bytes));
      if (rsp.valid && rsp.ready) begin
        if (pending_regions.size() == 0) begin
          $error("result transfer with nothing expected: base=%h bytes=%h log2=%0d failed=%b",
                 rsp.region_base, rsp.region_bytes, rsp.region_log2, rsp.failed);
          err_cnt++;
        end else begin
          want = pending_regions.pop_front();
          if (rsp.region_base !== want.base) begin
            $error("region_base: expected %h, got %h", want.base, rsp.region_base);
            err_cnt++;
          end
          if (rsp.region_bytes !== want.bytes) begin
            $error("region_bytes: expected %h, got %h", want.bytes, rsp.region_bytes);
            err_cnt++;
          end
          if (rsp.region_log2 !== want.lg) begin
            $error("region_log2: expected %0d, got %0d", want.lg, rsp.region_log2);
            err_cnt++;
          end
          if (rsp.failed !== want.failed) begin
            $error("failed: expected %b, got %b", want.failed, rsp.failed);
            err_cnt++;
          end
        end
      end
      open_cnt = pending_regions.size();
    end
  end

endmodule

// File: verif/mpu_region_rounder_tb.sv
module mpu_region_rounder_tb;
  import mrr_pkg::*;

  localparam int RAND_ITEMS  = 1300;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  int   err_cnt;
  int   open_cnt;
  int   accepted = 0;
  int   cycles = 0;
  logic calm;

  mrr_in_if  req();
  mrr_out_if rsp();

  mpu_region_rounder dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  mpu_region_rounder_chk chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (err_cnt),
    .pending (open_cnt)
  );

  always #6 clk = ~clk;

  // no random idling on either side during this window (the mid-run drain still idles the sender)
  assign calm = (accepted >= 500 && accepted < 800);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic offer_block(input logic [31:0] addr, input logic [31:0] len);
    if (!calm && $urandom_range(99) < 12) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.start_address <= addr;
    req.block_bytes   <= len;
    do @(posedge clk); while (!req.ready);
    accepted <= accepted + 1;
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted >= 300) begin
        hold_left = 400;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= 12);
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] mask;
    int unsigned pick;
    int unsigned k;
    rst               <= 1'b1;
    req.valid         <= 1'b0;
    req.start_address <= '0;
    req.block_bytes   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short blocks, minimum size, slack growth, limit and overflow cases
    offer_block(32'h0000_0000, 32'd0);
    offer_block(32'h0000_0000, 32'd31);
    offer_block(32'hFFFF_FFFF, 32'd1);
    offer_block(32'h0000_0000, 32'd32);
    offer_block(32'h0000_1000, 32'd33);
    offer_block(32'h0000_0010, 32'd32);
    offer_block(32'hFFFF_FFE0, 32'd32);
    offer_block(32'hFFFF_FFFF, 32'd32);
    offer_block(32'h0000_0020, 32'h0000_0020);
    offer_block(32'h0000_0000, 32'h4000_0000);
    offer_block(32'h4000_0000, 32'h4000_0000);
    offer_block(32'h0000_0000, 32'h4000_0001);
    offer_block(32'h3FFF_FFFF, 32'd32);
    offer_block(32'h3FFF_FFE0, 32'd32);
    offer_block(32'h1234_5678, 32'h8000_0000);
    offer_block(32'h0000_0000, 32'hFFFF_FFFF);
    offer_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_block(32'h8000_0000, 32'h0000_0100);
    offer_block(32'h7FFF_FFF0, 32'd64);
    offer_block(32'hAAAA_AAAA, 32'h5555_5555);
    offer_block(32'h5555_5555, 32'h0000_AAAA);
    offer_block(32'h2000_0001, 32'h1FFF_FFFF);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 700) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (open_cnt != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = $urandom_range(31, 0);
      end else if (pick < 16) begin
        len = $urandom;
      end else begin
        k   = (pick < 80) ? $urandom_range(12, 5) : $urandom_range(31, 13);
        len = $urandom_range(32'd1 << k, 32);
      end
      pick = $urandom_range(99);
      addr = $urandom;
      mask = (32'd1 << $urandom_range(31, 5)) - 32'd1;
      if (pick < 25)
        addr = addr & ~mask;
      else if (pick < 50)
        addr = (addr & ~mask) - $urandom_range(64, 1);
      offer_block(addr, len);
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
hdl/mrr_pkg.sv
hdl/mrr_in_if.sv
hdl/mrr_out_if.sv
hdl/mrr_datapath.sv
hdl/mrr_control.sv
hdl/mpu_region_rounder.sv
verif/mpu_region_rounder_chk.sv
verif/mpu_region_rounder_tb.sv
